>>> rtl/core/srcc_pkg.sv
// shared types and constants of the sparse row to column converter
package srcc_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_COL  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOT_CONV = 2'd3;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic CFG_NUM_COLS = 1'b0;
	localparam logic CFG_NUM_ROWS = 1'b1;

	typedef struct packed {
		logic [8:0]  col;
		logic [7:0]  row;
		logic [63:0] value;
	} ld_entry_t;

	typedef struct packed {
		logic [7:0]  row;
		logic [63:0] value;
	} cv_entry_t;

endpackage

>>> rtl/core/srcc_if.sv
// item channels of the sparse row to column converter
interface srcc_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [7:0]  row_index;
	logic [8:0]  col_number;
	logic [63:0] value_bits;
	logic        last;
	logic [10:0] read_position;

	modport source (output valid, mode, row_index, col_number, value_bits, last,
		read_position, input ready);
	modport sink (input valid, mode, row_index, col_number, value_bits, last,
		read_position, output ready);
endinterface

interface srcc_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] entry_value;
	logic [7:0]  entry_row;
	logic [10:0] column_start;
	logic [1:0]  status;

	modport source (output valid, entry_value, entry_row, column_start, status,
		input ready);
	modport sink (input valid, entry_value, entry_row, column_start, status,
		output ready);
endinterface

>>> rtl/core/sparse_row_to_column_convert.sv
// sparse row to column converter: load store, column count and scatter sequencer
// results are registered; a read item passes one memory read and then state S_RD
// throughput: one load item per cycle while results are taken and no conversion runs; a
// read item holds off the next item until its result is registered; the item marked last
// starts a conversion (clear, count, prefix sum, scatter) in the single-port column start memory
// reset clears control state and sets num_cols to 1; memories are not cleared
module sparse_row_to_column_convert
	import srcc_pkg::*;
#(
	parameter int MAX_NONZEROS = 1024,
	parameter int MAX_COLS     = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [8:0] cfg_data,
	srcc_req_if.sink   req,
	srcc_rsp_if.source rsp
);

	localparam int AW   = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
	localparam int CNTW = $clog2(MAX_NONZEROS + 1);
	localparam int CAW  = $clog2(MAX_COLS + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CLR  = 4'd2;
	localparam logic [3:0] S_KLD  = 4'd3;
	localparam logic [3:0] S_KRC  = 4'd4;
	localparam logic [3:0] S_KWR  = 4'd5;
	localparam logic [3:0] S_PRD  = 4'd6;
	localparam logic [3:0] S_PWR  = 4'd7;
	localparam logic [3:0] S_SLD  = 4'd8;
	localparam logic [3:0] S_SRC  = 4'd9;
	localparam logic [3:0] S_SWR  = 4'd10;

	ld_entry_t        ld_mem [MAX_NONZEROS];
	cv_entry_t        cv_mem [MAX_NONZEROS];
	logic [CNTW-1:0]  cs_mem [MAX_COLS+1];

	logic [3:0]       state_q;
	logic [8:0]       num_cols_q;
	logic [8:0]       ncv_q;
	logic [CNTW-1:0]  cnt_q;
	logic [CNTW-1:0]  placed_q;
	logic [CNTW-1:0]  eix_q;
	logic [CAW-1:0]   cix_q;
	logic [CNTW-1:0]  sum_q;
	logic             conv_q;
	logic [10:0]      rp_s1;
	logic [10:0]      rd_col_s1;
	logic             rd_conv_s1;

	logic             out_valid_q;
	logic [63:0]      value_q;
	logic [7:0]       row_q;
	logic [10:0]      cstart_q;
	logic [1:0]       status_q;

	ld_entry_t        ld_rd;
	cv_entry_t        cv_rd;
	logic [CNTW-1:0]  cs_rd;

	logic             ld_we;
	logic [AW-1:0]    ld_waddr;
	logic             cs_we;
	logic [CAW-1:0]   cs_addr;
	logic [CNTW-1:0]  cs_wd;
	logic             cv_we;

	logic [8:0]       nc;
	logic [10:0]      rd_col;
	logic             acc;
	logic [CNTW-1:0]  cnt_eff;
	logic             bad_col;
	logic             full;
	logic             rd_col_ok;
	logic             last_eix;
	logic [CNTW-1:0]  sum_n;

	assign nc        = (32'(num_cols_q) > MAX_COLS) ? 9'(MAX_COLS) : num_cols_q;
	assign rd_col    = (req.read_position <= 11'(nc)) ? req.read_position : 11'(nc);
	assign req.ready = (state_q == S_IDLE) && (!out_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign cnt_eff   = conv_q ? '0 : cnt_q;
	assign bad_col   = (req.col_number == 9'd0) || (req.col_number > nc);
	assign full      = !bad_col && (32'(cnt_eff) >= MAX_NONZEROS);
	assign ld_we     = acc && (req.mode == MODE_LOAD) && !bad_col && !full;
	assign ld_waddr  = cnt_eff[AW-1:0];
	assign rd_col_ok = (ld_rd.col != 9'd0) && (ld_rd.col <= nc);
	assign last_eix  = (eix_q + 1'b1) >= cnt_q;
	assign sum_n     = sum_q + cs_rd;
	assign cv_we     = (state_q == S_SWR);

	always_comb begin
		cs_we   = 1'b0;
		cs_addr = CAW'(rd_col - 11'd1);
		cs_wd   = '0;
		case (state_q)
			S_CLR: begin
				cs_we   = 1'b1;
				cs_addr = cix_q;
			end
			S_KRC: cs_addr = CAW'(ld_rd.col);
			S_KWR: begin
				cs_we   = 1'b1;
				cs_addr = CAW'(ld_rd.col);
				cs_wd   = cs_rd + 1'b1;
			end
			S_PRD: cs_addr = cix_q;
			S_PWR: begin
				cs_we   = 1'b1;
				cs_addr = cix_q;
				cs_wd   = sum_n;
			end
			S_SRC: cs_addr = CAW'(ld_rd.col - 9'd1);
			S_SWR: begin
				cs_we   = 1'b1;
				cs_addr = CAW'(ld_rd.col - 9'd1);
				cs_wd   = cs_rd + 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_we) begin
			ld_mem[ld_waddr] <= '{col: req.col_number, row: req.row_index,
				value: req.value_bits};
		end
		ld_rd <= ld_mem[eix_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cs_we) begin
			cs_mem[cs_addr] <= cs_wd;
		end
		cs_rd <= cs_mem[cs_addr];
	end

	always_ff @(posedge clk) begin
		if (cv_we) begin
			cv_mem[AW'(cs_rd)] <= '{row: ld_rd.row, value: ld_rd.value};
		end
		cv_rd <= cv_mem[AW'(req.read_position)];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rp_s1      <= req.read_position;
			rd_col_s1  <= rd_col;
			rd_conv_s1 <= conv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			num_cols_q  <= 9'd1;
			ncv_q       <= '0;
			cnt_q       <= '0;
			placed_q    <= '0;
			eix_q       <= '0;
			cix_q       <= '0;
			sum_q       <= '0;
			conv_q      <= 1'b0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			row_q       <= '0;
			cstart_q    <= '0;
			status_q    <= ST_OK;
		end else begin
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_NUM_COLS: num_cols_q <= cfg_data;
					CFG_NUM_ROWS: ;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc && req.mode == MODE_LOAD) begin
						out_valid_q <= 1'b1;
						value_q     <= '0;
						row_q       <= '0;
						cstart_q    <= '0;
						status_q    <= bad_col ? ST_BAD_COL : (full ? ST_FULL : ST_OK);
						conv_q      <= 1'b0;
						cnt_q       <= ld_we ? cnt_eff + 1'b1 : cnt_eff;
						if (req.last) begin
							cix_q   <= '0;
							ncv_q   <= nc;
							state_q <= S_CLR;
						end
					end else if (acc) begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					out_valid_q <= 1'b1;
					if (!rd_conv_s1) begin
						value_q  <= '0;
						row_q    <= '0;
						cstart_q <= '0;
						status_q <= ST_NOT_CONV;
					end else begin
						status_q <= ST_OK;
						if (32'(rp_s1) < 32'(placed_q)) begin
							value_q <= cv_rd.value;
							row_q   <= cv_rd.row;
						end else begin
							value_q <= '0;
							row_q   <= '0;
						end
						// column 0 and columns past the converted range hold no start
						if (rd_col_s1 == 11'd0 || rd_col_s1 > 11'(ncv_q)) begin
							cstart_q <= '0;
						end else begin
							cstart_q <= 11'(cs_rd);
						end
					end
					state_q <= S_IDLE;
				end
				S_CLR: begin
					if (cix_q == CAW'(nc)) begin
						eix_q   <= '0;
						state_q <= (cnt_q == '0) ? S_PRD : S_KLD;
						cix_q   <= CAW'(1);
						sum_q   <= '0;
						if (nc == 9'd0) begin
							placed_q <= '0;
							state_q  <= (cnt_q == '0) ? S_IDLE : S_SLD;
							conv_q   <= (cnt_q == '0);
						end
					end else begin
						cix_q <= cix_q + 1'b1;
					end
				end
				S_KLD: state_q <= S_KRC;
				S_KRC: begin
					if (rd_col_ok) begin
						state_q <= S_KWR;
					end else if (last_eix) begin
						state_q <= S_PRD;
					end else begin
						eix_q   <= eix_q + 1'b1;
						state_q <= S_KLD;
					end
				end
				S_KWR: begin
					if (last_eix) begin
						state_q <= S_PRD;
					end else begin
						eix_q   <= eix_q + 1'b1;
						state_q <= S_KLD;
					end
				end
				S_PRD: state_q <= S_PWR;
				S_PWR: begin
					sum_q <= sum_n;
					if (cix_q == CAW'(nc)) begin
						placed_q <= sum_n;
						eix_q    <= '0;
						if (cnt_q == '0) begin
							conv_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SLD;
						end
					end else begin
						cix_q   <= cix_q + 1'b1;
						state_q <= S_PRD;
					end
				end
				S_SLD: state_q <= S_SRC;
				S_SRC: begin
					if (rd_col_ok) begin
						state_q <= S_SWR;
					end else if (last_eix) begin
						conv_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						eix_q   <= eix_q + 1'b1;
						state_q <= S_SLD;
					end
				end
				S_SWR: begin
					if (last_eix) begin
						conv_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						eix_q   <= eix_q + 1'b1;
						state_q <= S_SLD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.entry_value  = value_q;
	assign rsp.entry_row    = row_q;
	assign rsp.column_start = cstart_q;
	assign rsp.status       = status_q;

	a_placed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		conv_q |-> placed_q <= cnt_q)
		else $error("converted entries exceed stored entries");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_NONZEROS)
		else $error("entry count beyond capacity");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> (state_q == S_IDLE) && !(rsp.valid && !rsp.ready))
		else $error("item accepted while busy or result blocked");

endmodule

>>> bench/tb_sparse_row_to_column_convert.sv
// testbench of the sparse row to column converter with scoreboard and transpose predictor
module tb_sparse_row_to_column_convert;
	import srcc_pkg::*;

	localparam int CAP          = 1024;
	localparam int COLS         = 256;
	localparam int SETTLE       = 8000;
	localparam int STALL_LIMIT  = 50000;
	localparam int ITEM_TARGET  = 1100;

	class transpose_scoreboard;
		typedef struct {
			logic [63:0] value;
			logic [7:0]  row;
			logic [10:0] start;
			logic [1:0]  status;
		} result_t;

		result_t     pending[$];
		logic [63:0] ld_val[CAP];
		logic [7:0]  ld_row[CAP];
		logic [8:0]  ld_col[CAP];
		logic [63:0] cv_val[CAP];
		logic [7:0]  cv_row[CAP];
		int          starts[COLS + 1];
		int          count;
		int          placed;
		bit          conv;
		logic [8:0]  ncols_reg;
		logic [8:0]  nrows_reg;
		int          errors;

		function new();
			ncols_reg = 1;
			nrows_reg = 1;
			count = 0;
			placed = 0;
			conv = 0;
			errors = 0;
			foreach (starts[i]) starts[i] = 0;
		endfunction

		function int eff_cols();
			return (ncols_reg > COLS) ? COLS : int'(ncols_reg);
		endfunction

		function void write_reg(logic idx, logic [8:0] d);
			if (idx == CFG_NUM_COLS) ncols_reg = d;
			else nrows_reg = d;
		endfunction

		function void transpose();
			int nc;
			int c;
			int p;
			int cur[COLS + 1];
			nc = eff_cols();
			foreach (starts[i]) starts[i] = 0;
			for (int i = 0; i < count; i++) begin
				c = ld_col[i];
				if (c >= 1 && c <= nc) starts[c]++;
			end
			for (int i = 1; i <= nc; i++) starts[i] += starts[i - 1];
			cur = starts;
			for (int i = 0; i < count; i++) begin
				c = ld_col[i];
				if (c < 1 || c > nc) continue;
				p = cur[c - 1];
				cur[c - 1]++;
				if (p < CAP) begin
					cv_val[p] = ld_val[i];
					cv_row[p] = ld_row[i];
				end
			end
			placed = starts[nc];
			conv = 1;
		endfunction

		function void note(logic mode, logic [7:0] row, logic [8:0] col, logic [63:0] val,
			logic last, logic [10:0] rp);
			result_t r;
			int nc;
			r.value = '0;
			r.row = '0;
			r.start = '0;
			r.status = ST_OK;
			if (mode == MODE_LOAD) begin
				if (conv) begin
					conv = 0;
					count = 0;
					placed = 0;
					foreach (starts[i]) starts[i] = 0;
				end
				nc = eff_cols();
				if (col < 1 || col > nc) begin
					r.status = ST_BAD_COL;
				end else if (count >= CAP) begin
					r.status = ST_FULL;
				end else begin
					ld_val[count] = val;
					ld_row[count] = row;
					ld_col[count] = col;
					count++;
				end
				if (last) transpose();
			end else if (!conv) begin
				r.status = ST_NOT_CONV;
			end else begin
				nc = eff_cols();
				if (rp < placed && rp < CAP) begin
					r.value = cv_val[rp];
					r.row = cv_row[rp];
				end
				r.start = (rp <= nc) ? starts[rp][10:0] : starts[nc][10:0];
			end
			pending.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(logic [63:0] value, logic [7:0] row, logic [10:0] start, logic [1:0] status);
			result_t e;
			if (pending.size() == 0) begin
				report("result with no item outstanding");
			end else begin
				e = pending.pop_front();
				if (value !== e.value)
					report($sformatf("entry_value %h, want %h", value, e.value));
				if (row !== e.row)
					report($sformatf("entry_row %0d, want %0d", row, e.row));
				if (start !== e.start)
					report($sformatf("column_start %0d, want %0d", start, e.start));
				if (status !== e.status)
					report($sformatf("status %0d, want %0d", status, e.status));
			end
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_index;
	logic [8:0] cfg_data;

	srcc_req_if req_ch();
	srcc_rsp_if rsp_ch();

	sparse_row_to_column_convert dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	transpose_scoreboard sb = new();
	int send_pct;
	int recv_pct;
	int sent_items;
	int quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check(rsp_ch.entry_value, rsp_ch.entry_row, rsp_ch.column_start, rsp_ch.status);
		rsp_ch.ready <= ($urandom_range(99) >= recv_pct);
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task send_item(logic mode, logic [7:0] row, logic [8:0] col, logic [63:0] val,
		logic last, logic [10:0] rp);
		while ($urandom_range(99) < send_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= mode;
		req_ch.row_index <= row;
		req_ch.col_number <= col;
		req_ch.value_bits <= val;
		req_ch.last <= last;
		req_ch.read_position <= rp;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note(mode, row, col, val, last, rp);
		sent_items++;
	endtask

	task drain();
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task set_reg(logic idx, logic [8:0] d);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, d);
	endtask

	task load_matrix(int n, int bad_pct, bit finish);
		int nc;
		logic [8:0] col;
		nc = sb.eff_cols();
		for (int i = 0; i < n; i++) begin
			if (nc == 0 || $urandom_range(99) < bad_pct)
				col = ($urandom_range(1) == 0 || nc >= 511) ? 9'd0 :
					9'($urandom_range(nc + 1, 511));
			else
				col = 9'($urandom_range(1, nc));
			send_item(MODE_LOAD, 8'($urandom_range(255)), col, {$urandom, $urandom},
				finish && (i == n - 1), 11'($urandom));
		end
	endtask

	task read_burst(int k);
		int nc;
		int r;
		int rp;
		nc = sb.eff_cols();
		for (int i = 0; i < k; i++) begin
			r = $urandom_range(9);
			if (r < 6) rp = $urandom_range(0, sb.placed + 2);
			else if (r < 8) rp = $urandom_range(0, nc + 2);
			else rp = $urandom_range(0, 2047);
			send_item(MODE_READ, 8'($urandom), 9'($urandom), {$urandom, $urandom},
				1'($urandom), 11'(rp));
		end
	endtask

	initial begin
		int phase;
		int phase_start;
		int pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_NUM_COLS;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_LOAD;
		req_ch.row_index = '0;
		req_ch.col_number = '0;
		req_ch.value_bits = '0;
		req_ch.last = 1'b0;
		req_ch.read_position = '0;
		rsp_ch.ready = 1'b0;
		send_pct = 0;
		recv_pct = 0;
		sent_items = 0;
		quiet_cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read before any conversion, bad columns, a pending load then conversion
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd0);
		send_item(MODE_LOAD, 8'd255, 9'd1, '1, 1'b0, 11'd0);
		send_item(MODE_LOAD, 8'd3, 9'd0, 64'h1234, 1'b0, 11'd0);
		send_item(MODE_LOAD, 8'd4, 9'd2, 64'h5678, 1'b0, 11'd0);
		send_item(MODE_READ, 8'd0, 9'd1, 64'd0, 1'b0, 11'd0);
		send_item(MODE_LOAD, 8'd0, 9'd1, 64'd0, 1'b1, 11'd0);
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd0);
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd1);
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd2);
		send_item(MODE_READ, '1, '1, '1, 1'b1, 11'd2047);
		set_reg(CFG_NUM_COLS, 9'd511);
		set_reg(CFG_NUM_ROWS, 9'd256);
		send_item(MODE_LOAD, 8'd7, 9'd256, 64'hdead_beef_0000_0001, 1'b0, 11'd0);
		send_item(MODE_LOAD, 8'd9, 9'd1, 64'h8000_0000_0000_0000, 1'b0, 11'd0);
		send_item(MODE_LOAD, 8'd10, 9'd256, 64'h1, 1'b0, 11'd0);
		send_item(MODE_LOAD, 8'd11, 9'd300, 64'h2, 1'b1, 11'd0);
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd0);
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd1);
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd2);
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd256);
		send_item(MODE_READ, 8'd0, 9'd0, 64'd0, 1'b0, 11'd257);

		// column count shrinks while a matrix is half loaded
		set_reg(CFG_NUM_COLS, 9'd64);
		load_matrix(10, 0, 0);
		set_reg(CFG_NUM_COLS, 9'd20);
		load_matrix(1, 0, 1);
		read_burst(12);

		// overfill the entry store
		set_reg(CFG_NUM_COLS, 9'd256);
		load_matrix(CAP + 6, 0, 1);
		read_burst(20);

		phase = 0;
		while (sent_items < ITEM_TARGET || phase < 4) begin
			case (phase % 6)
				0: set_reg(CFG_NUM_COLS, 9'd256);
				1: set_reg(CFG_NUM_COLS, 9'd1);
				2: set_reg(CFG_NUM_COLS, 9'($urandom_range(2, 40)));
				3: set_reg(CFG_NUM_COLS, 9'd0);
				4: set_reg(CFG_NUM_COLS, 9'($urandom_range(257, 511)));
				default: set_reg(CFG_NUM_COLS, 9'($urandom_range(41, 255)));
			endcase
			set_reg(CFG_NUM_ROWS, (phase % 3 == 0) ? 9'd1 :
				(phase % 3 == 1) ? 9'd511 : 9'($urandom_range(2, 510)));
			case (phase % 4)
				0: begin send_pct = 0;  recv_pct = 0;  end
				1: begin send_pct = 87; recv_pct = 0;  end
				2: begin send_pct = 0;  recv_pct = 87; end
				default: begin send_pct = 6; recv_pct = 6; end
			endcase
			phase_start = sent_items;
			while (sent_items - phase_start < 8) begin
				pick = $urandom_range(99);
				if (pick < 5) drain();
				if (pick < 80) begin
					load_matrix(($urandom_range(9) == 0) ? $urandom_range(13, 40) :
						$urandom_range(1, 12), 10, 1);
					read_burst($urandom_range(1, 8));
				end else if (pick < 90) begin
					read_burst($urandom_range(1, 4));
				end else begin
					load_matrix($urandom_range(1, 6), 30, 0);
					read_burst($urandom_range(1, 3));
				end
			end
			phase++;
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

>>> files.f
rtl/core/srcc_pkg.sv
rtl/core/srcc_if.sv
rtl/core/sparse_row_to_column_convert.sv
bench/tb_sparse_row_to_column_convert.sv
